// ===== rtl/core/bilinear_image_resize_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the bilinear image resize block.
// Both macros sample on i_clk and are switched off while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef BILINEAR_IMAGE_RESIZE_DEFINES_SVH
`define BILINEAR_IMAGE_RESIZE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BIR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bilinear_image_resize: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define BIR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bilinear_image_resize: next-cycle check failed");

`endif

// ===== rtl/core/bir_pkg.sv =====
// ---------------------------------------------------------------------------
// bir_pkg
// Constants, codes and shared types of the bilinear image resize block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bir_pkg;

    localparam int MAX_WIDTH    = 64;
    localparam int MAX_HEIGHT   = 64;
    localparam int MAX_CHANNELS = 3;
    localparam int FRAC_BITS    = 16;

    localparam int SAMPLE_W   = 16;
    localparam int COORD_W    = 10;
    localparam int CH_W       = 2;
    localparam int SRC_SIZE_W = 7;
    localparam int SC_SIZE_W  = 2;
    localparam int DST_SIZE_W = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    // Effective (clamped) size widths and in-store coordinate widths.
    localparam int SW_W = $clog2(MAX_WIDTH + 1);
    localparam int SH_W = $clog2(MAX_HEIGHT + 1);
    localparam int SC_W = $clog2(MAX_CHANNELS + 1);
    localparam int XW   = $clog2(MAX_WIDTH);
    localparam int YW   = $clog2(MAX_HEIGHT);

    // Ratio and mapped position widths.
    localparam int RATIO_W = SRC_SIZE_W + FRAC_BITS;
    localparam int PX_W    = RATIO_W + COORD_W;
    localparam int INT_W   = PX_W - FRAC_BITS;
    localparam int REM_W   = DST_SIZE_W;
    localparam int DCNT_W  = $clog2(RATIO_W);

    // Blend widths.
    localparam int WGT_W = FRAC_BITS + 1;
    localparam int TOP_W = SAMPLE_W + FRAC_BITS;
    localparam int ACC_W = TOP_W + FRAC_BITS + 1;
    localparam int RND_W = ACC_W - 2 * FRAC_BITS;

    // Store split into four banks by row and column parity.
    localparam int W_BANK     = (MAX_WIDTH + 1) / 2;
    localparam int H_BANK     = (MAX_HEIGHT + 1) / 2;
    localparam int BANK_DEPTH = MAX_CHANNELS * H_BANK * W_BANK;
    localparam int BA_W       = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

    // Queue between front and back.
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Reset values of the registers and the ratios that follow from them.
    localparam int SRC_W_RST = 64;
    localparam int SRC_H_RST = 64;
    localparam int SRC_C_RST = 3;
    localparam int DST_W_RST = 64;
    localparam int DST_H_RST = 64;
    localparam int SW_RST_EFF = (SRC_W_RST > MAX_WIDTH) ? MAX_WIDTH : SRC_W_RST;
    localparam int SH_RST_EFF = (SRC_H_RST > MAX_HEIGHT) ? MAX_HEIGHT : SRC_H_RST;
    localparam longint RATIO_X_RST =
        (longint'(SW_RST_EFF - 1) << FRAC_BITS) / longint'(DST_W_RST - 1);
    localparam longint RATIO_Y_RST =
        (longint'(SH_RST_EFF - 1) << FRAC_BITS) / longint'(DST_H_RST - 1);

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_CHANNELS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT   = 3'd4;

    typedef struct packed {
        logic [SW_W-1:0]       sw;
        logic [SH_W-1:0]       sh;
        logic [SC_W-1:0]       sc;
        logic [DST_SIZE_W-1:0] dw;
        logic [DST_SIZE_W-1:0] dh;
    } t_cfg;

    typedef struct packed {
        logic                kind;
        logic                oor;
        logic [CH_W-1:0]     ch;
        logic [XW-1:0]       lcol;
        logic [YW-1:0]       lrow;
        logic [SAMPLE_W-1:0] sample;
        logic [PX_W-1:0]     px;
        logic [PX_W-1:0]     py;
    } t_item;

    typedef struct packed {
        logic               full;
        logic               empty;
        logic [Q_CNT_W-1:0] count;
    } t_q_status;

    typedef struct packed {
        logic busy;
    } t_div_status;

endpackage

`default_nettype wire

// ===== rtl/core/bilinear_image_resize.sv =====
// A query or a rejected load beat passes the queue and then the fetch, blend and result
// registers before it is presented at the output; an in-range load gives no result and is
// stored as the back pops it from the queue, later while the back is stalled.
// Throughput: one beat per cycle unless the queue fills or the divider is busy, set by the
// four-bank store that serves all four neighbours with one read port each; a 4-entry queue
// parts front from back. A configuration write starts a shared ratio divider, one quotient
// bit per cycle; input and configuration ready stay low meanwhile. Reset is synchronous.
// ---------------------------------------------------------------------------
// bilinear_image_resize
// Corner-aligned bilinear scaler: loads fill a banked sample store, queries
// return the rounded blend of the four source samples around a mapped point.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "bilinear_image_resize_defines.svh"

module bilinear_image_resize import bir_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Input item channel.
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic                  i_kind,
    input  wire logic [COORD_W-1:0]    i_col,
    input  wire logic [COORD_W-1:0]    i_row,
    input  wire logic [CH_W-1:0]       i_channel,
    input  wire logic [SAMPLE_W-1:0]   i_sample,
    // Result channel.
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [SAMPLE_W-1:0]        o_value,
    output logic                       o_out_of_range,
    // Configuration write channel.
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Raw register contents, as written.
    logic [SRC_SIZE_W-1:0] r_src_width, r_src_height;
    logic [SC_SIZE_W-1:0]  r_src_channels;
    logic [DST_SIZE_W-1:0] r_dst_width, r_dst_height;

    t_cfg               cfg;
    logic [RATIO_W-1:0] ratio_x, ratio_y;
    t_div_status        div_st;
    t_item              front_item, head;
    t_q_status          q_st;
    logic               in_beat, cfg_beat, pop;

    // Both sides of the block wait while the ratios are being recomputed, so no
    // query is ever mapped with a half-updated ratio.
    assign o_in_ready  = !q_st.full && !div_st.busy;
    assign o_cfg_ready = !div_st.busy;
    assign in_beat     = i_in_valid && o_in_ready;
    assign cfg_beat    = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width    <= SRC_SIZE_W'(SRC_W_RST);
            r_src_height   <= SRC_SIZE_W'(SRC_H_RST);
            r_src_channels <= SC_SIZE_W'(SRC_C_RST);
            r_dst_width    <= DST_SIZE_W'(DST_W_RST);
            r_dst_height   <= DST_SIZE_W'(DST_H_RST);
        end else if (cfg_beat) begin
            unique case (i_cfg_index)
                REG_SRC_WIDTH:    r_src_width    <= i_cfg_data[SRC_SIZE_W-1:0];
                REG_SRC_HEIGHT:   r_src_height   <= i_cfg_data[SRC_SIZE_W-1:0];
                REG_SRC_CHANNELS: r_src_channels <= i_cfg_data[SC_SIZE_W-1:0];
                REG_DST_WIDTH:    r_dst_width    <= i_cfg_data;
                REG_DST_HEIGHT:   r_dst_height   <= i_cfg_data;
                default:          ;
            endcase
        end
    end

    // Effective sizes: source sizes are clamped to the store, and a zero size of
    // any kind behaves as a size of one.
    always_comb begin
        if (r_src_width == '0)
            cfg.sw = SW_W'(1);
        else if (32'(r_src_width) > MAX_WIDTH)
            cfg.sw = SW_W'(MAX_WIDTH);
        else
            cfg.sw = SW_W'(r_src_width);
        if (r_src_height == '0)
            cfg.sh = SH_W'(1);
        else if (32'(r_src_height) > MAX_HEIGHT)
            cfg.sh = SH_W'(MAX_HEIGHT);
        else
            cfg.sh = SH_W'(r_src_height);
        if (r_src_channels == '0)
            cfg.sc = SC_W'(1);
        else if (32'(r_src_channels) > MAX_CHANNELS)
            cfg.sc = SC_W'(MAX_CHANNELS);
        else
            cfg.sc = SC_W'(r_src_channels);
        cfg.dw = (r_dst_width == '0)  ? DST_SIZE_W'(1) : r_dst_width;
        cfg.dh = (r_dst_height == '0) ? DST_SIZE_W'(1) : r_dst_height;
    end

    // Any write starts the divider, which reads the updated sizes in its load states.
    bir_ratio_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (cfg_beat),
        .i_cfg     (cfg),
        .o_ratio_x (ratio_x),
        .o_ratio_y (ratio_y),
        .o_status  (div_st)
    );

    // The front range-checks every beat and multiplies query coordinates by the
    // ratios; the product goes straight into the queue.
    bir_front u_front (
        .i_kind    (i_kind),
        .i_col     (i_col),
        .i_row     (i_row),
        .i_channel (i_channel),
        .i_sample  (i_sample),
        .i_cfg     (cfg),
        .i_ratio_x (ratio_x),
        .i_ratio_y (ratio_y),
        .o_item    (front_item)
    );

    bir_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (in_beat),
        .i_item   (front_item),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_st)
    );

    // The back handles beats in queue order, so a load is always written before
    // any later query reads the same sample.
    bir_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_head         (head),
        .i_head_valid   (!q_st.empty),
        .o_pop          (pop),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_value        (o_value),
        .o_out_of_range (o_out_of_range)
    );

    // A rejected beat always reports a zero value.
    `BIR_ASSERT_NOW(a_oor_value_zero, o_out_valid && o_out_of_range, o_value == '0)
    // Every configuration write leaves the ratios being recomputed.
    `BIR_ASSERT_NEXT(a_cfg_starts_div, cfg_beat, div_st.busy)
    // The queue never holds more beats than it has slots.
    `BIR_ASSERT_NOW(a_queue_bound, 1'b1, q_st.count <= Q_CNT_W'(Q_DEPTH))

endmodule

`default_nettype wire

// ===== rtl/core/bir_ratio_div.sv =====
// ---------------------------------------------------------------------------
// bir_ratio_div
// Radix-2 restoring divider that works out both axis ratios after a write.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bir_ratio_div import bir_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire t_cfg               i_cfg,
    output logic [RATIO_W-1:0]      o_ratio_x,
    output logic [RATIO_W-1:0]      o_ratio_y,
    output t_div_status             o_status
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_LOAD_X = 5'b00010,
        S_RUN_X  = 5'b00100,
        S_LOAD_Y = 5'b01000,
        S_RUN_Y  = 5'b10000
    } t_state;

    t_state              r_state, n_state;
    logic [RATIO_W-1:0]  r_dvd;
    logic [REM_W-1:0]    r_dvs;
    logic [REM_W-1:0]    r_rem;
    logic [RATIO_W-1:0]  r_quo;
    logic [DCNT_W-1:0]   r_cnt;
    logic [RATIO_W-1:0]  r_ratio_x, r_ratio_y;

    logic [REM_W:0]      rem_sh;
    logic                ge;
    logic [REM_W-1:0]    n_rem;
    logic [RATIO_W-1:0]  n_quo;
    logic                last;

    always_comb begin
        rem_sh = {r_rem, r_dvd[RATIO_W-1]};
        ge     = (rem_sh >= {1'b0, r_dvs});
        n_rem  = ge ? REM_W'(rem_sh - {1'b0, r_dvs}) : rem_sh[REM_W-1:0];
        n_quo  = {r_quo[RATIO_W-2:0], ge};
        last   = (r_cnt == DCNT_W'(RATIO_W - 1));
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_start) n_state = S_LOAD_X;
            S_LOAD_X: n_state = S_RUN_X;
            S_RUN_X:  if (last) n_state = S_LOAD_Y;
            S_LOAD_Y: n_state = S_RUN_Y;
            S_RUN_Y:  if (last) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ratio_x <= RATIO_W'(RATIO_X_RST);
            r_ratio_y <= RATIO_W'(RATIO_Y_RST);
        end else begin
            r_state <= n_state;
            if (last && (r_state == S_RUN_X)) begin
                r_ratio_x <= (r_dvs == '0) ? '0 : n_quo;
            end
            if (last && (r_state == S_RUN_Y)) begin
                r_ratio_y <= (r_dvs == '0) ? '0 : n_quo;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_LOAD_X || r_state == S_LOAD_Y) begin
            if (r_state == S_LOAD_X) begin
                r_dvd <= RATIO_W'(i_cfg.sw - SW_W'(1)) << FRAC_BITS;
                r_dvs <= i_cfg.dw - DST_SIZE_W'(1);
            end else begin
                r_dvd <= RATIO_W'(i_cfg.sh - SH_W'(1)) << FRAC_BITS;
                r_dvs <= i_cfg.dh - DST_SIZE_W'(1);
            end
            r_rem <= '0;
            r_quo <= '0;
            r_cnt <= '0;
        end else begin
            r_dvd <= {r_dvd[RATIO_W-2:0], 1'b0};
            r_rem <= n_rem;
            r_quo <= n_quo;
            r_cnt <= r_cnt + DCNT_W'(1);
        end
    end

    assign o_ratio_x     = r_ratio_x;
    assign o_ratio_y     = r_ratio_y;
    assign o_status.busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

// ===== rtl/core/bir_front.sv =====
// ---------------------------------------------------------------------------
// bir_front
// Classifies an incoming beat and maps a query position into the source.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bir_front import bir_pkg::*; (
    input  wire logic                i_kind,
    input  wire logic [COORD_W-1:0]  i_col,
    input  wire logic [COORD_W-1:0]  i_row,
    input  wire logic [CH_W-1:0]     i_channel,
    input  wire logic [SAMPLE_W-1:0] i_sample,
    input  wire t_cfg                i_cfg,
    input  wire logic [RATIO_W-1:0]  i_ratio_x,
    input  wire logic [RATIO_W-1:0]  i_ratio_y,
    output t_item                    o_item
);

    logic ch_bad, load_bad, query_bad;

    always_comb begin
        ch_bad    = (32'(i_channel) >= 32'(i_cfg.sc));
        load_bad  = (32'(i_col) >= 32'(i_cfg.sw)) || (32'(i_row) >= 32'(i_cfg.sh));
        query_bad = (32'(i_col) >= 32'(i_cfg.dw)) || (32'(i_row) >= 32'(i_cfg.dh));

        o_item.kind   = i_kind;
        o_item.oor    = ch_bad || ((i_kind == KIND_LOAD) ? load_bad : query_bad);
        o_item.ch     = i_channel;
        o_item.lcol   = i_col[XW-1:0];
        o_item.lrow   = i_row[YW-1:0];
        o_item.sample = i_sample;
        o_item.px     = PX_W'(i_ratio_x) * PX_W'(i_col);
        o_item.py     = PX_W'(i_ratio_y) * PX_W'(i_row);
    end

endmodule

`default_nettype wire

// ===== rtl/core/bir_queue.sv =====
// ---------------------------------------------------------------------------
// bir_queue
// Short first-in first-out queue of classified beats.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bir_queue import bir_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    input  wire logic  i_pop,
    output t_item      o_head,
    output t_q_status  o_status
);

    t_item              r_slot [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wptr, r_rptr;
    logic [Q_CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wptr <= r_wptr + Q_PTR_W'(1);
            if (i_pop)  r_rptr <= r_rptr + Q_PTR_W'(1);
            if (i_push && !i_pop) begin
                r_count <= r_count + Q_CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - Q_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_slot[r_wptr] <= i_item;
    end

    assign o_head         = r_slot[r_rptr];
    assign o_status.full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_status.count = r_count;

endmodule

`default_nettype wire

// ===== rtl/core/bir_back.sv =====
// ---------------------------------------------------------------------------
// bir_back
// Banked sample store, four-sample fetch, bilinear blend and result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bir_back import bir_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_cfg                i_cfg,
    input  wire t_item               i_head,
    input  wire logic                i_head_valid,
    output logic                     o_pop,
    input  wire logic                i_out_ready,
    output logic                     o_out_valid,
    output logic [SAMPLE_W-1:0]      o_value,
    output logic                     o_out_of_range
);

    function automatic logic [BA_W-1:0] bank_addr(logic [CH_W-1:0] ch,
                                                  logic [YW-1:0] r, logic [XW-1:0] c);
        return BA_W'((32'(ch) * H_BANK + 32'(r >> 1)) * W_BANK + 32'(c >> 1));
    endfunction

    logic advance, load_wr;

    // Fetch stage signals.
    logic [INT_W-1:0]     xi, yi;
    logic [XW-1:0]        xl, xh;
    logic [YW-1:0]        yl, yh;
    logic [FRAC_BITS-1:0] fx, fy;
    logic                 hx, hy;
    logic [BA_W-1:0]      raddr [4];
    logic [1:0]           wbank;
    logic [BA_W-1:0]      waddr;

    logic [SAMPLE_W-1:0]  r_q [4];
    logic                 r2_valid, r2_res, r2_oor, r2_hx, r2_hy, r2_bx, r2_by;
    logic [FRAC_BITS-1:0] r2_fx, r2_fy;

    // Horizontal blend stage.
    logic [SAMPLE_W-1:0]  p00, p01, p10, p11;
    logic [WGT_W-1:0]     wx0, wy0;
    logic [TOP_W:0]       top_sum, bot_sum;

    logic                 r3_valid, r3_res, r3_oor;
    logic [TOP_W-1:0]     r3_top, r3_bot;
    logic [FRAC_BITS-1:0] r3_fy;

    logic [ACC_W-1:0]     acc;
    logic [RND_W-1:0]     rnd;
    logic [SAMPLE_W-1:0]  blend;

    logic                 r_out_valid, r_out_oor;
    logic [SAMPLE_W-1:0]  r_value;

    assign advance = !r_out_valid || i_out_ready;
    assign o_pop   = advance && i_head_valid;
    assign load_wr = o_pop && (i_head.kind == KIND_LOAD) && !i_head.oor;

    always_comb begin
        xi = i_head.px[PX_W-1:FRAC_BITS];
        yi = i_head.py[PX_W-1:FRAC_BITS];
        fx = i_head.px[FRAC_BITS-1:0];
        fy = i_head.py[FRAC_BITS-1:0];
        xl = (xi > INT_W'(i_cfg.sw - SW_W'(1))) ? XW'(i_cfg.sw - SW_W'(1)) : xi[XW-1:0];
        yl = (yi > INT_W'(i_cfg.sh - SH_W'(1))) ? YW'(i_cfg.sh - SH_W'(1)) : yi[YW-1:0];
        hx = (fx != '0) && ((32'(xl) + 32'd1) < 32'(i_cfg.sw));
        hy = (fy != '0) && ((32'(yl) + 32'd1) < 32'(i_cfg.sh));
        xh = hx ? xl + XW'(1) : xl;
        yh = hy ? yl + YW'(1) : yl;
        for (int b = 0; b < 4; b++) begin
            raddr[b] = bank_addr(i_head.ch,
                                 (yl[0] == b[1]) ? yl : yh,
                                 (xl[0] == b[0]) ? xl : xh);
        end
        wbank = {i_head.lrow[0], i_head.lcol[0]};
        waddr = bank_addr(i_head.ch, i_head.lrow, i_head.lcol);
    end

    for (genvar g = 0; g < 4; g++) begin : g_bank
        logic [SAMPLE_W-1:0] bank_mem [BANK_DEPTH];
        always_ff @(posedge i_clk) begin
            if (load_wr && (wbank == 2'(g))) bank_mem[waddr] <= i_head.sample;
            if (advance) r_q[g] <= bank_mem[raddr[g]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r2_valid    <= o_pop;
            r3_valid    <= r2_valid;
            r_out_valid <= r3_valid && r3_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r2_res <= (i_head.kind == KIND_QUERY) || i_head.oor;
            r2_oor <= i_head.oor;
            r2_fx  <= fx;
            r2_fy  <= fy;
            r2_hx  <= hx;
            r2_hy  <= hy;
            r2_bx  <= xl[0];
            r2_by  <= yl[0];
        end
    end

    always_comb begin
        p00 = r_q[{r2_by, r2_bx}];
        p01 = r2_hx ? r_q[{r2_by, ~r2_bx}] : p00;
        p10 = r2_hy ? r_q[{~r2_by, r2_bx}] : p00;
        p11 = r_q[{r2_hy ? ~r2_by : r2_by, r2_hx ? ~r2_bx : r2_bx}];
        wx0 = WGT_W'(1 << FRAC_BITS) - WGT_W'(r2_fx);
        top_sum = (TOP_W+1)'(p00) * (TOP_W+1)'(wx0) + (TOP_W+1)'(p01) * (TOP_W+1)'(r2_fx);
        bot_sum = (TOP_W+1)'(p10) * (TOP_W+1)'(wx0) + (TOP_W+1)'(p11) * (TOP_W+1)'(r2_fx);
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r3_res <= r2_res;
            r3_oor <= r2_oor;
            r3_top <= top_sum[TOP_W-1:0];
            r3_bot <= bot_sum[TOP_W-1:0];
            r3_fy  <= r2_fy;
        end
    end

    always_comb begin
        wy0   = WGT_W'(1 << FRAC_BITS) - WGT_W'(r3_fy);
        acc   = ACC_W'(r3_top) * ACC_W'(wy0) + ACC_W'(r3_bot) * ACC_W'(r3_fy)
              + (ACC_W'(1) << (2 * FRAC_BITS - 1));
        rnd   = acc[ACC_W-1:2*FRAC_BITS];
        blend = (rnd > RND_W'({SAMPLE_W{1'b1}})) ? {SAMPLE_W{1'b1}} : rnd[SAMPLE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_oor <= r3_oor;
            r_value   <= r3_oor ? '0 : blend;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_value        = r_value;
    assign o_out_of_range = r_out_oor;

endmodule

`default_nettype wire

// ===== verif/tb_bilinear_image_resize.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_bilinear_image_resize
// Self-checking bench for the bilinear scaler. A local copy of the sample
// store and of the size registers predicts every result beat; a monitor
// compares each accepted beat with the oldest prediction. Each size phase sets
// the sizes, fills the source image, then runs a random mix of queries,
// loads and out-of-range beats while both sides stall at random.
// ---------------------------------------------------------------------------

module tb_bilinear_image_resize;
    import bir_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    // Latency allowance before a register write and at the end of the run.
    localparam int SETTLE_CYCLES = 8;
    // Register indexes that the block does not decode.
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;
    localparam int STORE_DEPTH = MAX_CHANNELS * MAX_HEIGHT * MAX_WIDTH;

    typedef struct {
        logic [SAMPLE_W-1:0] value;
        logic                oor;
    } t_pixel_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic                  i_kind = KIND_LOAD;
    logic [COORD_W-1:0]    i_col = '0;
    logic [COORD_W-1:0]    i_row = '0;
    logic [CH_W-1:0]       i_channel = '0;
    logic [SAMPLE_W-1:0]   i_sample = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [SAMPLE_W-1:0]   o_value;
    logic                  o_out_of_range;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    bilinear_image_resize uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_kind         (i_kind),
        .i_col          (i_col),
        .i_row          (i_row),
        .i_channel      (i_channel),
        .i_sample       (i_sample),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_value        (o_value),
        .o_out_of_range (o_out_of_range),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Local picture of the block: sample store and raw register contents.
    logic [SAMPLE_W-1:0]   pix_store [STORE_DEPTH];
    logic [SRC_SIZE_W-1:0] src_w_reg = 7'd64;
    logic [SRC_SIZE_W-1:0] src_h_reg = 7'd64;
    logic [SC_SIZE_W-1:0]  src_c_reg = 2'd3;
    logic [DST_SIZE_W-1:0] dst_w_reg = 11'd64;
    logic [DST_SIZE_W-1:0] dst_h_reg = 11'd64;

    t_pixel_result pending_pixels[$];
    int mismatches = 0;
    int beats_sent = 0;
    int beats_checked = 0;
    int cycles = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_off_cycles = 0;

    // Effective sizes after clamping, as the block sees them.
    function automatic int eff_sw();
        return (src_w_reg == 0) ? 1 : (src_w_reg > MAX_WIDTH) ? MAX_WIDTH : int'(src_w_reg);
    endfunction
    function automatic int eff_sh();
        return (src_h_reg == 0) ? 1 : (src_h_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(src_h_reg);
    endfunction
    function automatic int eff_sc();
        return (src_c_reg == 0) ? 1 :
               (src_c_reg > MAX_CHANNELS) ? MAX_CHANNELS : int'(src_c_reg);
    endfunction
    function automatic int eff_dw();
        return (dst_w_reg == 0) ? 1 : int'(dst_w_reg);
    endfunction
    function automatic int eff_dh();
        return (dst_h_reg == 0) ? 1 : int'(dst_h_reg);
    endfunction

    function automatic int pix_addr(int ch, int r, int c);
        return (ch * MAX_HEIGHT + r) * MAX_WIDTH + c;
    endfunction

    // Corner-aligned ratio in fixed point, truncated toward zero.
    function automatic longint unsigned map_ratio(int src, int dst);
        if (dst <= 1) return 0;
        return (longint'(src - 1) << FRAC_BITS) / longint'(dst - 1);
    endfunction

    // Applies one accepted beat to the local store and works out the result.
    function automatic bit resample_pixel(logic kind, int col, int row, int ch,
                                          logic [SAMPLE_W-1:0] smp,
                                          output t_pixel_result res);
        longint unsigned one, px, py, fx, fy, top, bot, acc;
        int sw, sh, sc, xl, xh, yl, yh;
        sw = eff_sw();
        sh = eff_sh();
        sc = eff_sc();
        one = longint'(1) << FRAC_BITS;
        res.value = '0;
        res.oor = 1'b1;
        if (kind == KIND_LOAD) begin
            if (col >= sw || row >= sh || ch >= sc) return 1'b1;
            pix_store[pix_addr(ch, row, col)] = smp;
            return 1'b0;
        end
        if (col >= eff_dw() || row >= eff_dh() || ch >= sc) return 1'b1;
        px = map_ratio(sw, eff_dw()) * longint'(col);
        py = map_ratio(sh, eff_dh()) * longint'(row);
        xl = int'(px >> FRAC_BITS);
        yl = int'(py >> FRAC_BITS);
        fx = px & (one - 1);
        fy = py & (one - 1);
        if (xl > sw - 1) xl = sw - 1;
        if (yl > sh - 1) yl = sh - 1;
        xh = (fx != 0 && xl + 1 < sw) ? xl + 1 : xl;
        yh = (fy != 0 && yl + 1 < sh) ? yl + 1 : yl;
        top = longint'(pix_store[pix_addr(ch, yl, xl)]) * (one - fx)
            + longint'(pix_store[pix_addr(ch, yl, xh)]) * fx;
        bot = longint'(pix_store[pix_addr(ch, yh, xl)]) * (one - fx)
            + longint'(pix_store[pix_addr(ch, yh, xh)]) * fx;
        acc = top * (one - fy) + bot * fy;
        acc = (acc + (longint'(1) << (2 * FRAC_BITS - 1))) >> (2 * FRAC_BITS);
        if (acc > 64'hFFFF) acc = 64'hFFFF;
        res.value = acc[SAMPLE_W-1:0];
        res.oor = 1'b0;
        return 1'b1;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("[%0t] %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // Sends one beat on the input channel. Valid is only dropped when the
    // sender decides to idle, so back-to-back beats keep it high.
    task automatic send_beat(logic kind, int col, int row, int ch, int smp);
        t_pixel_result res;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_col      <= col[COORD_W-1:0];
        i_row      <= row[COORD_W-1:0];
        i_channel  <= ch[CH_W-1:0];
        i_sample   <= smp[SAMPLE_W-1:0];
        do @(posedge i_clk); while (!o_in_ready);
        beats_sent++;
        if (resample_pixel(kind, col[COORD_W-1:0], row[COORD_W-1:0], ch[CH_W-1:0],
                           smp[SAMPLE_W-1:0], res))
            pending_pixels.push_back(res);
    endtask

    // Stops offering beats and waits until every predicted result arrived.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, int data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data[CFG_DATA_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_SRC_WIDTH:    src_w_reg = data[SRC_SIZE_W-1:0];
            REG_SRC_HEIGHT:   src_h_reg = data[SRC_SIZE_W-1:0];
            REG_SRC_CHANNELS: src_c_reg = data[SC_SIZE_W-1:0];
            REG_DST_WIDTH:    dst_w_reg = data[DST_SIZE_W-1:0];
            REG_DST_HEIGHT:   dst_h_reg = data[DST_SIZE_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_sizes(int sw, int sh, int sc, int dw, int dh);
        drain_results();
        write_register(REG_SRC_WIDTH, sw);
        write_register(REG_SRC_HEIGHT, sh);
        write_register(REG_SRC_CHANNELS, sc);
        write_register(REG_DST_WIDTH, dw);
        write_register(REG_DST_HEIGHT, dh);
    endtask

    // Loads every sample of the configured source image, so that no query
    // of this phase reads an entry that was never written.
    task automatic fill_source();
        int pick;
        for (int ch = 0; ch < eff_sc(); ch++)
            for (int r = 0; r < eff_sh(); r++)
                for (int c = 0; c < eff_sw(); c++) begin
                    pick = $urandom_range(0, 9);
                    send_beat(KIND_LOAD, c, r, ch,
                              (pick == 0) ? 0 : (pick == 1) ? 16'hFFFF : $urandom_range(0, 65535));
                end
    endtask

    // Random traffic over a filled image: mostly in-range queries, some
    // reloads, some rejected beats and some raw noise on every field.
    task automatic random_traffic(int count);
        int pick, dw_lim, dh_lim;
        dw_lim = (eff_dw() > 1024) ? 1024 : eff_dw();
        dh_lim = (eff_dh() > 1024) ? 1024 : eff_dh();
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 68)
                send_beat(KIND_QUERY, $urandom_range(0, dw_lim - 1),
                          $urandom_range(0, dh_lim - 1), $urandom_range(0, eff_sc() - 1),
                          $urandom_range(0, 65535));
            else if (pick < 83)
                send_beat(KIND_LOAD, $urandom_range(0, eff_sw() - 1),
                          $urandom_range(0, eff_sh() - 1), $urandom_range(0, eff_sc() - 1),
                          $urandom_range(0, 65535));
            else if (pick < 91)
                // Past one edge: channel, column or row.
                case ($urandom_range(0, 2))
                    0: send_beat($urandom_range(0, 1), 0, 0, $urandom_range(eff_sc(), 3),
                                 $urandom_range(0, 65535));
                    1: send_beat(KIND_LOAD, $urandom_range(eff_sw(), 1023), 0, 0,
                                 $urandom_range(0, 65535));
                    default: send_beat(KIND_QUERY, 0, $urandom_range(dh_lim, 1023), 0, 0);
                endcase
            else
                send_beat($urandom_range(0, 1), $urandom_range(0, 1023),
                          $urandom_range(0, 1023), $urandom_range(0, 3),
                          $urandom_range(0, 65535));
        end
    endtask

    // Result monitor: each accepted beat is matched with the oldest prediction.
    always @(posedge i_clk) begin
        t_pixel_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_pixels.size() == 0) begin
                report_mismatch("result beats with no prediction waiting", 1, 0);
            end else begin
                want = pending_pixels.pop_front();
                beats_checked++;
                if (o_value !== want.value) report_mismatch("value", o_value, want.value);
                if (o_out_of_range !== want.oor)
                    report_mismatch("out_of_range", o_out_of_range, want.oor);
            end
        end
    end

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(posedge i_clk) begin
        if (hold_off_cycles > 0) begin
            i_out_ready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Extremes of the samples at the reset sizes, where the ratio is exactly
    // one, then loads and queries outside every size, and unknown
    // register indexes.
    task automatic test_reset_sizes();
        send_beat(KIND_LOAD, 0, 0, 0, 16'hFFFF);
        send_beat(KIND_LOAD, 63, 63, 2, 0);
        send_beat(KIND_LOAD, 1, 0, 0, 16'h1234);
        send_beat(KIND_QUERY, 0, 0, 0, 16'hFFFF);
        send_beat(KIND_QUERY, 63, 63, 2, 0);
        send_beat(KIND_QUERY, 1, 0, 0, 0);
        send_beat(KIND_LOAD, 64, 0, 0, 7);
        send_beat(KIND_LOAD, 0, 1023, 1, 7);
        send_beat(KIND_LOAD, 0, 0, 3, 7);
        send_beat(KIND_QUERY, 64, 0, 0, 0);
        send_beat(KIND_QUERY, 1023, 1023, 0, 0);
        send_beat(KIND_QUERY, 0, 0, 3, 0);
        drain_results();
        write_register(REG_UNMAPPED_LO, 11'h7FF);
        write_register(REG_UNMAPPED_HI, 1);
        // The sizes must be unchanged: the same corner reads back.
        send_beat(KIND_QUERY, 63, 63, 2, 0);
    endtask

    // A fraction of exactly one half must round up.
    task automatic test_half_rounding();
        set_sizes(2, 1, 1, 3, 1);
        send_beat(KIND_LOAD, 0, 0, 0, 1);
        send_beat(KIND_LOAD, 1, 0, 0, 2);
        send_beat(KIND_QUERY, 1, 0, 0, 0);
        send_beat(KIND_QUERY, 2, 0, 0, 0);
        send_beat(KIND_QUERY, 3, 0, 0, 0);
    endtask

    task automatic test_size_phase(int sw, int sh, int sc, int dw, int dh, int count);
        set_sizes(sw, sh, sc, dw, dh);
        fill_source();
        random_traffic(count);
    endtask

    // The receiver holds off for a long stretch while beats keep coming,
    // then the sender pauses until everything has drained.
    task automatic test_backpressure();
        int saved_idle;
        saved_idle = send_idle_pct;
        send_idle_pct = 0;
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        hold_off_cycles <= 300;
        random_traffic(40);
        drain_results();
        random_traffic(20);
        send_idle_pct = saved_idle;
    endtask

    initial begin
        for (int i = 0; i < STORE_DEPTH; i++) pix_store[i] = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_sizes();
        test_half_rounding();

        // Sender idles often and the receiver more.
        send_idle_pct = 37;
        recv_idle_pct = 52;
        test_size_phase(4, 3, 2, 7, 5, 130);
        test_size_phase(1, 1, 1, 1, 1, 100);
        test_size_phase(0, 0, 0, 0, 0, 100);
        test_backpressure();

        // Roles swapped.
        send_idle_pct = 52;
        recv_idle_pct = 37;
        test_size_phase(127, 1, 0, 1024, 3, 130);
        test_size_phase(2, 64, 1, 2047, 1023, 130);
        test_size_phase(5, 7, 3, 13, 2, 130);

        // Neither side idles.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_size_phase(64, 2, 1, 100, 64, 130);
        test_size_phase(3, 3, 3, 2, 9, 130);
        test_size_phase(9, 6, 2, 17, 11, 130);
        test_backpressure();

        drain_results();
        $display("Sent %0d input beats over eleven size settings, checked %0d result beats.",
                 beats_sent, beats_checked);
        $display("Covered clamped and zero sizes, half rounding, rejects and long stalls.");
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
